FILE: sv/eso_pkg.sv
// ----------------------------------------------------------------------------
// eso_pkg
// Shared types, register indexes, operation codes and saturation helpers
// for the extended state observer step.
// ----------------------------------------------------------------------------
package eso_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned MulW    = 33;
    localparam int unsigned ProdW   = 2 * MulW;

    localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_ONE   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_TWO   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_THREE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_INPUT_COEF = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_DAMP_COEF  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INV_GAIN_B = 3'd6;

    // product sequence, one operation per cycle through the multiplier
    localparam logic [3:0] OP_T1   = 4'd0;
    localparam logic [3:0] OP_T2   = 4'd1;
    localparam logic [3:0] OP_T3   = 4'd2;
    localparam logic [3:0] OP_CIN  = 4'd3;
    localparam logic [3:0] OP_CDM  = 4'd4;
    localparam logic [3:0] OP_NU   = 4'd5;
    localparam logic [3:0] OP_NZ1  = 4'd6;
    localparam logic [3:0] OP_NZ3  = 4'd7;
    localparam logic [3:0] OP_NZ2  = 4'd8;
    localparam logic [3:0] OP_LAST = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef logic signed [MulW-1:0]  t_mul_op;
    typedef logic signed [ProdW-1:0] t_prod;

    function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
        logic [ProdW-32:0] top;
        top = v[ProdW-1:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end else if (v[ProdW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    // floor shift of a product to Q16.16, then clamp
    function automatic logic signed [31:0] shift_sat(input logic signed [ProdW-1:0] p,
                                                     input logic by24);
        logic signed [ProdW-1:0] s;
        s = by24 ? (p >>> 24) : (p >>> 16);
        return sat32(s);
    endfunction

endpackage

FILE: sv/eso_mul.sv
// ----------------------------------------------------------------------------
// eso_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module eso_mul import eso_pkg::*; (
    input  logic    i_clk,
    input  t_mul_op i_a,
    input  t_mul_op i_b,
    output t_prod   o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/extended_state_observer_step.sv
// ----------------------------------------------------------------------------
// extended_state_observer_step
// Third-order linear extended state observer, one Euler step per item.
// ----------------------------------------------------------------------------
// An item is accepted only while the block is idle. The error is formed on
// acceptance, then nine products run one per cycle through a single shared
// 33x33 multiplier whose registered output is scaled, clamped and folded into
// the new estimates. Once all nine are done, the result is loaded into the
// output register as soon as that register is free, and the next item can be
// taken only after that. The estimates and the previous control value reset
// to zero; config registers reset to their defaults.
module extended_state_observer_step import eso_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_data,
    // input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // measured[31:0], command[47:32]
    // result items
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata    // est_pos, est_vel, est_dist, ctrl_out
);

    t_state r_state;
    logic [3:0] r_cnt;

    logic [23:0] r_h;
    logic [30:0] r_g1, r_g2, r_g3;
    logic signed [31:0] r_ci, r_cd, r_invb;

    logic signed [31:0] r_z1, r_z2, r_z3, r_u;
    logic signed [31:0] r_e, r_a1, r_t2, r_t3, r_cin, r_inner;
    logic signed [31:0] r_nz1, r_nz2, r_nz3, r_nu;
    logic signed [15:0] r_cmd;

    logic         r_m_valid;
    logic [127:0] r_m_data;

    t_mul_op mul_a, mul_b;
    t_prod   prod;
    logic [3:0] cons_op;
    logic signed [31:0] scaled;
    logic signed [34:0] inner_sum;
    logic signed [32:0] e_diff;
    logic accept;
    logic out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign e_diff  = 33'(r_z1) - 33'($signed(s_axis_tdata[31:0]));
    assign cons_op = r_cnt - 4'd1;
    assign scaled  = shift_sat(prod, !(cons_op == OP_T1 || cons_op == OP_T2 ||
                                       cons_op == OP_T3));
    assign inner_sum = 35'(r_z3) - 35'(r_t2) + 35'(r_cin) - 35'(scaled);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_cnt)
            OP_T1:  begin mul_a = {2'b00, r_g1}; mul_b = 33'(r_e); end
            OP_T2:  begin mul_a = {2'b00, r_g2}; mul_b = 33'(r_e); end
            OP_T3:  begin mul_a = {2'b00, r_g3}; mul_b = 33'(r_e); end
            OP_CIN: begin mul_a = 33'(r_ci);     mul_b = 33'(r_u); end
            OP_CDM: begin mul_a = 33'(r_cd);     mul_b = 33'(r_z2); end
            OP_NU:  begin
                mul_a = {r_cmd[15], r_cmd, 16'b0} - 33'(r_z3);
                mul_b = 33'(r_invb);
            end
            OP_NZ1: begin mul_a = {9'b0, r_h}; mul_b = 33'(r_a1); end
            OP_NZ3: begin mul_a = {9'b0, r_h}; mul_b = 33'(r_t3); end
            OP_NZ2: begin mul_a = {9'b0, r_h}; mul_b = 33'(r_inner); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    eso_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= 24'd33554;
            r_g1   <= 31'd1966080;
            r_g2   <= 31'd19660800;
            r_g3   <= 31'd196608000;
            r_ci   <= 32'sd69066;
            r_cd   <= 32'sd15344157;
            r_invb <= 32'sd8388608;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STEP_SIZE:  r_h    <= i_cfg_data[23:0];
                CFG_GAIN_ONE:   r_g1   <= i_cfg_data[30:0];
                CFG_GAIN_TWO:   r_g2   <= i_cfg_data[30:0];
                CFG_GAIN_THREE: r_g3   <= i_cfg_data[30:0];
                CFG_INPUT_COEF: r_ci   <= i_cfg_data;
                CFG_DAMP_COEF:  r_cd   <= i_cfg_data;
                CFG_INV_GAIN_B: r_invb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and estimates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
            r_z1      <= '0;
            r_z2      <= '0;
            r_z3      <= '0;
            r_u       <= '0;
        end else begin
            if (m_axis_tready && r_state != ST_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_e     <= sat32(66'(e_diff));
                        r_cmd   <= s_axis_tdata[47:32];
                        r_cnt   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != 4'd0) begin
                        case (cons_op)
                            OP_T1:  r_a1    <= sat32(66'(33'(r_z2) - 33'(scaled)));
                            OP_T2:  r_t2    <= scaled;
                            OP_T3:  r_t3    <= scaled;
                            OP_CIN: r_cin   <= scaled;
                            OP_CDM: r_inner <= sat32(66'(inner_sum));
                            OP_NU:  r_nu    <= scaled;
                            OP_NZ1: r_nz1   <= sat32(66'(33'(r_z1) + 33'(scaled)));
                            OP_NZ3: r_nz3   <= sat32(66'(33'(r_z3) - 33'(scaled)));
                            OP_NZ2: r_nz2   <= sat32(66'(33'(r_z2) + 33'(scaled)));
                            default: ;
                        endcase
                    end
                    if (r_cnt == OP_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_nu, r_nz3, r_nz2, r_nz1};
                        r_z1      <= r_nz1;
                        r_z2      <= r_nz2;
                        r_z3      <= r_nz3;
                        r_u       <= r_nu;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/eso_chk.sv
// ----------------------------------------------------------------------------
// eso_chk
// Port-level checks for the observer step, bound to the top level.
// ----------------------------------------------------------------------------
module eso_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // one item at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after accept");

    // no result appears in the cycle after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared one cycle after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result item dropped or changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("outputs not cleared by reset");

endmodule

bind extended_state_observer_step eso_chk u_eso_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
